// File: rtl/o2g_pkg.sv
// Shared types, constants and the arctangent lookup function for the odometry-to-grid pose tracker.
// Used by o2g_cordic_step, o2g_mul and odometry_to_grid_pose_update_core.
package o2g_pkg;

	localparam int GRID_COLS    = 1024;
	localparam int GRID_ROWS    = 1024;
	localparam int CORDIC_STEPS = 16;

	localparam int ATAN_ENTRIES = 24;
	localparam int SHIFT_W      = 5;
	localparam int ITER_W       = $clog2(CORDIC_STEPS);
	localparam int DW           = 40;
	localparam int ACC_W        = 64;
	localparam int MUL_AW       = 21;
	localparam int MUL_BW       = 25;
	localparam int MUL_PW       = MUL_AW + MUL_BW;
	localparam int HALF_W       = 20;
	localparam int DCELL_W      = 28;

	localparam logic [23:0] INV_GAIN_Q24  = 24'd10188013;
	localparam logic [15:0] CPM_RESET     = 16'd5120;
	localparam logic [31:0] QUARTER_TURN  = 32'h4000_0000;
	localparam logic [31:0] HALF_TURN     = 32'h8000_0000;
	localparam logic [15:0] COL_RESET     = 16'(GRID_COLS / 2);
	localparam logic [15:0] ROW_RESET     = 16'(GRID_ROWS / 2);

	typedef struct packed {
		logic signed [31:0] odom_x;
		logic signed [31:0] odom_y;
		logic [15:0]        odom_heading;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] cell_x;
		logic signed [15:0] cell_y;
		logic [15:0]        map_heading;
	} out_item_t;

	typedef struct packed {
		logic               rotate;
		logic [SHIFT_W-1:0] shift;
	} cordic_ctl_t;

	typedef enum logic [11:0] {
		ST_IDLE     = 12'b0000_0000_0001,
		ST_INIT     = 12'b0000_0000_0010,
		ST_VEC      = 12'b0000_0000_0100,
		ST_LEN_MUL  = 12'b0000_0000_1000,
		ST_ROT_INIT = 12'b0000_0001_0000,
		ST_ROT      = 12'b0000_0010_0000,
		ST_XG_MUL   = 12'b0000_0100_0000,
		ST_YG_MUL   = 12'b0000_1000_0000,
		ST_XS_MUL   = 12'b0001_0000_0000,
		ST_YS_MUL   = 12'b0010_0000_0000,
		ST_UPDATE   = 12'b0100_0000_0000,
		ST_SPARE    = 12'b1000_0000_0000
	} state_t;

	function automatic logic [31:0] atan_turns(input logic [SHIFT_W-1:0] idx);
		logic [31:0] r;
		unique case (idx)
			5'd0:    r = 32'h20000000;
			5'd1:    r = 32'h12E4051E;
			5'd2:    r = 32'h09FB385B;
			5'd3:    r = 32'h051111D4;
			5'd4:    r = 32'h028B0D43;
			5'd5:    r = 32'h0145D7E1;
			5'd6:    r = 32'h00A2F61E;
			5'd7:    r = 32'h00517C55;
			5'd8:    r = 32'h0028BE53;
			5'd9:    r = 32'h00145F2F;
			5'd10:   r = 32'h000A2F98;
			5'd11:   r = 32'h000517CC;
			5'd12:   r = 32'h00028BE6;
			5'd13:   r = 32'h000145F3;
			5'd14:   r = 32'h0000A2FA;
			5'd15:   r = 32'h0000517D;
			5'd16:   r = 32'h000028BE;
			5'd17:   r = 32'h0000145F;
			5'd18:   r = 32'h00000A30;
			5'd19:   r = 32'h00000518;
			5'd20:   r = 32'h0000028C;
			5'd21:   r = 32'h00000146;
			5'd22:   r = 32'h000000A3;
			5'd23:   r = 32'h00000051;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/o2g_cordic_step.sv
// One shared CORDIC micro-rotation for both the vectoring and the rotating pass.
// Depends on o2g_pkg for the data width, the control struct and the arctangent table.
module o2g_cordic_step (
	input  o2g_pkg::cordic_ctl_t           ctl,
	input  logic signed [o2g_pkg::DW-1:0]  x,
	input  logic signed [o2g_pkg::DW-1:0]  y,
	input  logic [31:0]                    z,
	output logic signed [o2g_pkg::DW-1:0]  x_next,
	output logic signed [o2g_pkg::DW-1:0]  y_next,
	output logic [31:0]                    z_next
);
	import o2g_pkg::*;

	logic                 cw;
	logic signed [DW-1:0] xs;
	logic signed [DW-1:0] ys;
	logic [31:0]          ang;

	assign cw  = ctl.rotate ? z[31] : ~y[DW-1];
	assign xs  = x >>> ctl.shift;
	assign ys  = y >>> ctl.shift;
	assign ang = atan_turns(ctl.shift);

	always_comb begin
		if (cw) begin
			x_next = x + ys;
			y_next = y - xs;
			z_next = z + ang;
		end else begin
			x_next = x - ys;
			y_next = y + xs;
			z_next = z - ang;
		end
	end

endmodule

// File: rtl/o2g_mul.sv
// Shared partial-product multiplier: one half of a 40-bit operand times a 24-bit coefficient.
// Depends on o2g_pkg for the operand and product widths.
module o2g_mul (
	input  logic signed [o2g_pkg::DW-1:0]     op,
	input  logic [23:0]                       coef,
	input  logic                              hi,
	output logic signed [o2g_pkg::MUL_PW-1:0] prod
);
	import o2g_pkg::*;

	logic signed [MUL_AW-1:0] a;
	logic signed [MUL_BW-1:0] b;

	assign a    = hi ? MUL_AW'(signed'(op[DW-1:HALF_W])) : {1'b0, op[HALF_W-1:0]};
	assign b    = {1'b0, coef};
	assign prod = a * b;

endmodule

// File: rtl/odometry_to_grid_pose_update_core.sv
// Odometry-to-grid pose tracker: one result item per input item. An item passes through setup,
// a CORDIC_STEPS vectoring pass, a length-gain multiply, angle setup, a CORDIC_STEPS rotating pass,
// four multiplies and an update (which waits while out_stall holds the output), on the shared CORDIC
// step and multiplier. A new item is taken only while the sequencer is idle.
// Asynchronous active-low reset clears the previous odometry and map heading, centres the grid cell,
// restores cells_per_meter to 5120 and empties the output register.
module odometry_to_grid_pose_update_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  o2g_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output o2g_pkg::out_item_t out_item,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_data
);
	import o2g_pkg::*;

	state_t                   state_q;
	logic [ITER_W-1:0]        iter_q;
	logic [1:0]               ph_q;
	logic [15:0]              cpm_q;
	logic signed [31:0]       prev_x_q;
	logic signed [31:0]       prev_y_q;
	logic [15:0]              prev_h_q;
	logic signed [15:0]       grid_col_q;
	logic signed [15:0]       grid_row_q;
	logic [15:0]              grid_heading_q;
	in_item_t                 cur_q;
	logic signed [DW-1:0]     x_q;
	logic signed [DW-1:0]     y_q;
	logic [31:0]              z_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [DCELL_W-1:0] dcol_q;
	logic signed [DCELL_W-1:0] drow_q;
	logic                     out_valid_q;
	out_item_t                out_q;

	logic                     in_acc;
	logic                     out_free;
	cordic_ctl_t              cctl;
	logic signed [DW-1:0]     cx_next;
	logic signed [DW-1:0]     cy_next;
	logic [31:0]              cz_next;
	logic signed [DW-1:0]     mul_op;
	logic [23:0]              mul_coef;
	logic signed [MUL_PW-1:0] mul_prod;
	logic signed [ACC_W-1:0]  prod_ext;
	logic signed [32:0]       dx;
	logic signed [32:0]       dy;
	logic signed [DW-1:0]     dx_w;
	logic signed [DW-1:0]     dy_w;
	logic [31:0]              phi;
	logic [31:0]              phi_chk;
	logic signed [ACC_W-1:0]  rnd_sum;
	logic signed [DCELL_W-1:0] dcell;
	logic signed [DCELL_W:0]  col_sum;
	logic signed [DCELL_W:0]  row_sum;
	logic signed [15:0]       col_sat;
	logic signed [15:0]       row_sat;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !(out_valid_q && out_stall);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	assign cctl.rotate = (state_q == ST_ROT);
	assign cctl.shift  = SHIFT_W'(iter_q);

	o2g_cordic_step u_step (
		.ctl    (cctl),
		.x      (x_q),
		.y      (y_q),
		.z      (z_q),
		.x_next (cx_next),
		.y_next (cy_next),
		.z_next (cz_next)
	);

	always_comb begin
		mul_coef = INV_GAIN_Q24;
		mul_op   = x_q;
		if ((state_q == ST_YG_MUL) || (state_q == ST_YS_MUL)) begin
			mul_op = y_q;
		end
		if ((state_q == ST_XS_MUL) || (state_q == ST_YS_MUL)) begin
			mul_coef = {8'd0, cpm_q};
		end
	end

	o2g_mul u_mul (
		.op   (mul_op),
		.coef (mul_coef),
		.hi   (ph_q[0]),
		.prod (mul_prod)
	);

	assign prod_ext = ACC_W'(mul_prod);

	assign dx   = 33'(prev_x_q) - 33'(cur_q.odom_x);
	assign dy   = 33'(prev_y_q) - 33'(cur_q.odom_y);
	assign dx_w = DW'(dx) <<< 4;
	assign dy_w = DW'(dy) <<< 4;

	assign phi     = {grid_heading_q, 16'd0} + {prev_h_q, 16'd0} - z_q + QUARTER_TURN;
	assign phi_chk = phi + QUARTER_TURN;

	assign rnd_sum = acc_q + ACC_W'(64'sd134217728) - ACC_W'({63'd0, acc_q[ACC_W-1]});
	assign dcell   = rnd_sum[28 +: DCELL_W];

	assign col_sum = (DCELL_W + 1)'(grid_col_q) + (DCELL_W + 1)'(dcol_q);
	assign row_sum = (DCELL_W + 1)'(grid_row_q) + (DCELL_W + 1)'(drow_q);

	always_comb begin
		priority if (col_sum > (DCELL_W + 1)'(32767)) begin
			col_sat = 16'sh7FFF;
		end else if (col_sum < -(DCELL_W + 1)'(32768)) begin
			col_sat = -16'sh8000;
		end else begin
			col_sat = col_sum[15:0];
		end
		priority if (row_sum > (DCELL_W + 1)'(32767)) begin
			row_sat = 16'sh7FFF;
		end else if (row_sum < -(DCELL_W + 1)'(32768)) begin
			row_sat = -16'sh8000;
		end else begin
			row_sat = row_sum[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			iter_q         <= '0;
			ph_q           <= '0;
			cpm_q          <= CPM_RESET;
			prev_x_q       <= '0;
			prev_y_q       <= '0;
			prev_h_q       <= '0;
			grid_col_q     <= signed'(COL_RESET);
			grid_row_q     <= signed'(ROW_RESET);
			grid_heading_q <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				cpm_q <= cfg_data;
			end
			if (out_valid_q && !out_stall && (state_q != ST_UPDATE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_INIT;
					end
				end
				ST_INIT: begin
					iter_q  <= '0;
					state_q <= ST_VEC;
				end
				ST_VEC: begin
					if (iter_q == ITER_W'(CORDIC_STEPS - 1)) begin
						iter_q  <= '0;
						ph_q    <= '0;
						state_q <= ST_LEN_MUL;
					end else begin
						iter_q <= iter_q + 1'b1;
					end
				end
				ST_ROT_INIT: begin
					iter_q  <= '0;
					state_q <= ST_ROT;
				end
				ST_ROT: begin
					if (iter_q == ITER_W'(CORDIC_STEPS - 1)) begin
						iter_q  <= '0;
						ph_q    <= '0;
						state_q <= ST_XG_MUL;
					end else begin
						iter_q <= iter_q + 1'b1;
					end
				end
				ST_LEN_MUL, ST_XG_MUL, ST_YG_MUL, ST_XS_MUL, ST_YS_MUL: begin
					if (ph_q == 2'd2) begin
						ph_q <= '0;
						unique case (state_q)
							ST_LEN_MUL: state_q <= ST_ROT_INIT;
							ST_XG_MUL:  state_q <= ST_YG_MUL;
							ST_YG_MUL:  state_q <= ST_XS_MUL;
							ST_XS_MUL:  state_q <= ST_YS_MUL;
							default:    state_q <= ST_UPDATE;
						endcase
					end else begin
						ph_q <= ph_q + 1'b1;
					end
				end
				ST_UPDATE: begin
					if (out_free) begin
						grid_col_q     <= col_sat;
						grid_row_q     <= row_sat;
						grid_heading_q <= grid_heading_q + prev_h_q - cur_q.odom_heading;
						prev_x_q       <= cur_q.odom_x;
						prev_y_q       <= cur_q.odom_y;
						prev_h_q       <= cur_q.odom_heading;
						out_valid_q    <= 1'b1;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cur_q <= in_item;
		end
		unique case (state_q)
			ST_INIT: begin
				if (dx_w[DW-1]) begin
					x_q <= -dx_w;
					y_q <= -dy_w;
					z_q <= HALF_TURN;
				end else begin
					x_q <= dx_w;
					y_q <= dy_w;
					z_q <= '0;
				end
			end
			ST_VEC, ST_ROT: begin
				x_q <= cx_next;
				y_q <= cy_next;
				z_q <= cz_next;
			end
			ST_ROT_INIT: begin
				if (phi_chk[31]) begin
					x_q <= -x_q;
					z_q <= phi ^ HALF_TURN;
				end else begin
					z_q <= phi;
				end
			end
			ST_LEN_MUL, ST_XG_MUL, ST_YG_MUL, ST_XS_MUL, ST_YS_MUL: begin
				unique case (ph_q)
					2'd0: acc_q <= prod_ext;
					2'd1: acc_q <= acc_q + (prod_ext <<< HALF_W);
					default: begin
						unique case (state_q)
							ST_LEN_MUL: begin
								x_q <= acc_q[ACC_W-1:24];
								y_q <= '0;
							end
							ST_XG_MUL: x_q    <= acc_q[ACC_W-1:24];
							ST_YG_MUL: y_q    <= acc_q[ACC_W-1:24];
							ST_XS_MUL: dcol_q <= dcell;
							default:   drow_q <= dcell;
						endcase
					end
				endcase
			end
			ST_UPDATE: begin
				if (out_free) begin
					out_q.cell_x      <= col_sat;
					out_q.cell_y      <= row_sat;
					out_q.map_heading <= grid_heading_q + prev_h_q - cur_q.odom_heading;
				end
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	a_out_from_update: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_UPDATE))
		else $error("Result item appeared without an update step.");

	a_iter_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_VEC || state_q == ST_ROT) |-> (iter_q <= ITER_W'(CORDIC_STEPS - 1)))
		else $error("CORDIC step counter out of range.");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q <= 2'd2)
		else $error("Multiplier phase counter out of range.");

	a_pose_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(state_q == ST_UPDATE && out_free) |=> $stable(grid_heading_q) && $stable(prev_h_q))
		else $error("Pose state changed outside the update step.");
`endif

endmodule
